>>> src/trial_division_prime_factorizer_core_macros.svh
// assertion macros shared by the factorizer modules
// no dependencies; included by the modules that carry assertions
`ifndef TRIAL_DIVISION_PRIME_FACTORIZER_CORE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_FACTORIZER_CORE_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define TDPF_ASSERT_HOLDS(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define TDPF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tdpf_pkg.sv
// shared types and constants of the trial division factorizer
// no dependencies; used by all factorizer modules
package tdpf_pkg;

	// fixed field widths and default value width
	localparam int FIELD_BITS     = 31;
	localparam int VALUE_BITS_DEF = 31;

	// first factor stripped and first odd trial divisor
	localparam int EVEN_FACTOR = 2;
	localparam int FIRST_ODD   = 3;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ONE  = 2'd1,
		STAT_ZERO = 2'd2
	} status_t;

	// one result transaction
	typedef struct packed {
		logic [FIELD_BITS-1:0] factor;
		logic                  last;
		status_t               status;
	} res_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

>>> src/tdpf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tdpf_pkg and the assertion macro header
`include "trial_division_prime_factorizer_core_macros.svh"

module tdpf_div #(
	parameter int VB = tdpf_pkg::VALUE_BITS_DEF,
	parameter int DW = tdpf_pkg::VALUE_BITS_DEF / 2 + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VB-1:0]         dividend,
	input  logic [DW-1:0]         divisor,
	output logic [VB-1:0]         quotient,
	output tdpf_pkg::div_stat_t   stat
);

	localparam int CW = $clog2(VB + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] part_q;
	logic [DW-1:0] dvs_q;
	logic [VB-1:0] quo_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] part_n;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial  = {part_q, quo_q[VB-1]};
		diff   = trial - {1'b0, dvs_q};
		ge     = (trial >= {1'b0, dvs_q});
		part_n = ge ? diff[DW-1:0] : trial[DW-1:0];
	end

	// step counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(VB);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift registers for partial remainder and dividend/quotient
	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= '0;
			dvs_q  <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			part_q <= part_n;
			quo_q  <= {quo_q[VB-2:0], ge};
		end
	end

	assign quotient      = quo_q;
	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (part_q == '0);

	`TDPF_ASSERT_HOLDS(a_start_idle, clk, arst_n, start, !busy_q, "divider started while busy")
	`TDPF_ASSERT_NEXT(a_done_hold, clk, arst_n, done_q && !start, done_q, "divider result dropped")

endmodule

>>> src/tdpf_outreg.sv
// output register holding one result transaction
// depends on tdpf_pkg and the assertion macro header
`include "trial_division_prime_factorizer_core_macros.svh"

module tdpf_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  tdpf_pkg::res_t load_res,
	input  logic           stall,
	output logic           valid,
	output tdpf_pkg::res_t res,
	output logic           free
);

	logic           valid_q;
	tdpf_pkg::res_t res_q;

	// slot is free when empty or being taken this cycle
	assign free = !valid_q || !stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign valid = valid_q;
	assign res   = res_q;

	`TDPF_ASSERT_HOLDS(a_no_overwrite, clk, arst_n, load, !(valid_q && stall), "result overwritten")

endmodule

>>> src/trial_division_prime_factorizer_core.sv
// Sequence: factors of two are stripped first, then each odd trial divisor whose square
// does not exceed the remainder is tried on the bit-serial divider (VB = value width).
// VB is 31 by default. Worst case for 31 bits is about 23170 trial divisors.
// Throughput: one item at a time; the next item is taken once the last result is loaded.
// Reset: asynchronous, active low; sequencer idle, no result valid.
`include "trial_division_prime_factorizer_core_macros.svh"

module trial_division_prime_factorizer_core #(
	parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tdpf_pkg::FIELD_BITS-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tdpf_pkg::FIELD_BITS-1:0] factor,
	output logic                            last,
	output logic [1:0]                      status
);

	localparam int FB = tdpf_pkg::FIELD_BITS;
	localparam int VB = (VALUE_BITS < FB) ? VALUE_BITS : FB;
	localparam int DW = VB / 2 + 2;
	localparam int SW = 2 * DW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SPEC = 5'b00010,
		S_TWO  = 5'b00100,
		S_CHK  = 5'b01000,
		S_DIV  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [VB-1:0]     rem_q, rem_d;
	logic [DW-1:0]     d_q, d_d;
	logic [SW-1:0]     sq_q, sq_d;
	tdpf_pkg::status_t spec_q, spec_d;

	logic                 want;
	logic                 push;
	logic                 free;
	tdpf_pkg::res_t       push_res;
	tdpf_pkg::res_t       out_res;
	logic                 div_start;
	logic [VB-1:0]        quo;
	tdpf_pkg::div_stat_t  div_stat;
	logic [VB-1:0]        vin;

	assign vin      = value[VB-1:0];
	assign in_stall = (state_q != S_IDLE);
	assign push     = want && free;

	// sequencer: 0 and 1 give a status result; else strip twos, then odd trial divisors on the serial divider
	always_comb begin
		state_d   = state_q;
		rem_d     = rem_q;
		d_d       = d_q;
		sq_d      = sq_q;
		spec_d    = spec_q;
		want      = 1'b0;
		div_start = 1'b0;
		push_res  = '{factor: '0, last: 1'b0, status: tdpf_pkg::STAT_OK};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rem_d = vin;
					if (vin <= VB'(1)) begin
						spec_d  = (vin == '0) ? tdpf_pkg::STAT_ZERO : tdpf_pkg::STAT_ONE;
						state_d = S_SPEC;
					end else begin
						state_d = S_TWO;
					end
				end
			end
			S_SPEC: begin
				want            = 1'b1;
				push_res.last   = 1'b1;
				push_res.status = spec_q;
				if (free) begin
					state_d = S_IDLE;
				end
			end
			S_TWO: begin
				if (!rem_q[0]) begin
					want            = 1'b1;
					push_res.factor = FB'(tdpf_pkg::EVEN_FACTOR);
					push_res.last   = (rem_q == VB'(tdpf_pkg::EVEN_FACTOR));
					if (free) begin
						rem_d = rem_q >> 1;
						if (push_res.last) begin
							state_d = S_IDLE;
						end
					end
				end else begin
					d_d     = DW'(tdpf_pkg::FIRST_ODD);
					sq_d    = SW'(tdpf_pkg::FIRST_ODD * tdpf_pkg::FIRST_ODD);
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sq_q <= SW'(rem_q)) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					// leftover remainder is prime
					want            = 1'b1;
					push_res.factor = FB'(rem_q);
					push_res.last   = 1'b1;
					if (free) begin
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					if (div_stat.rem_zero) begin
						want            = 1'b1;
						push_res.factor = FB'(d_q);
						push_res.last   = (quo == VB'(1));
						if (free) begin
							rem_d   = quo;
							state_d = push_res.last ? S_IDLE : S_CHK;
						end
					end else begin
						// next odd divisor, square kept by (d+2)^2 = d^2 + 4d + 4
						d_d     = d_q + DW'(2);
						sq_d    = sq_q + SW'({d_q, 2'b00}) + SW'(4);
						state_d = S_CHK;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		d_q    <= d_d;
		sq_q   <= sq_d;
		spec_q <= spec_d;
	end

	// serial divider used for every trial division
	tdpf_div #(
		.VB(VB),
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rem_q),
		.divisor  (d_q),
		.quotient (quo),
		.stat     (div_stat)
	);

	// result register toward the output channel
	tdpf_outreg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (push),
		.load_res (push_res),
		.stall    (out_stall),
		.valid    (out_valid),
		.res      (out_res),
		.free     (free)
	);

	assign factor = out_res.factor;
	assign last   = out_res.last;
	assign status = out_res.status;

	`TDPF_ASSERT_HOLDS(a_odd_work, clk, arst_n, state_q == S_CHK || state_q == S_DIV, d_q[0] && rem_q[0], "even divisor or remainder in trial loop")
	`TDPF_ASSERT_NEXT(a_last_idle, clk, arst_n, push && push_res.last, state_q == S_IDLE, "last result did not end the item")
	`TDPF_ASSERT_HOLDS(a_div_quiet, clk, arst_n, state_q == S_IDLE, !div_stat.busy, "divider running while idle")

endmodule
